// ===== rtl/sgmd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_pkg
// shared types, register codes and the arctangent table of the sobel unit
// ---------------------------------------------------------------------------
package sgmd_pkg;

    localparam int CFG_W    = 12;
    localparam int POS_W    = 11;
    localparam int MAG_W    = 13;
    localparam int DIR_W    = 14;
    localparam int ROW_W    = 11;
    localparam int HGT_W    = 13;
    localparam int Z_W      = 22;
    localparam int CORDIC_N = 16;

    localparam logic [11:0] MAX_HEIGHT = 12'd2048;

    // register indexes
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;
    localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd1;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [1:0]       channel_count;
    } t_cfg;

    // atan(2^-i) in units of pi/4096 with 8 fraction bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 22'sd262144;
            4'd1:    v = 22'sd154753;
            4'd2:    v = 22'sd81767;
            4'd3:    v = 22'sd41506;
            4'd4:    v = 22'sd20834;
            4'd5:    v = 22'sd10427;
            4'd6:    v = 22'sd5215;
            4'd7:    v = 22'sd2608;
            4'd8:    v = 22'sd1304;
            4'd9:    v = 22'sd652;
            4'd10:   v = 22'sd326;
            4'd11:   v = 22'sd163;
            4'd12:   v = 22'sd81;
            4'd13:   v = 22'sd41;
            4'd14:   v = 22'sd20;
            default: v = 22'sd10;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sgmd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_queue
// small register fifo with full and empty flags
// ---------------------------------------------------------------------------
module sgmd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/sgmd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_front
// pixel intake, line stores, 3x3 window and gradient jobs per output pixel
// ---------------------------------------------------------------------------
module sgmd_front #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 8,
    parameter int JOB_W       = 2 * (SAMPLE_BITS + 5) + 2 * sgmd_pkg::POS_W + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sgmd_pkg::t_cfg         i_cfg,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample_a,
    input  logic [SAMPLE_BITS-1:0] i_sample_b,
    input  logic [SAMPLE_BITS-1:0] i_sample_c,
    output logic                   o_job_push,
    input  logic                   i_job_full,
    output logic [JOB_W-1:0]       o_job
);
    localparam int PIX_W = SAMPLE_BITS + 2;
    localparam int G_W   = PIX_W + 3;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [PIX_W-1:0] mem_near [MAX_WIDTH];
    logic [PIX_W-1:0] mem_far  [MAX_WIDTH];

    logic [1:0]       r_state;
    logic [AW-1:0]    r_col;
    logic [sgmd_pkg::ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_pix, r_mid_rd, r_far_rd;
    logic [PIX_W-1:0] r_win [3][3];
    logic [3:0]       r_jobs;
    logic [1:0]       r_kind;
    logic             r_lastcol, r_lastrow;

    logic             accept;
    logic [PIX_W-1:0] pix_sum, top_v;
    logic [EW-1:0]    w_eff;
    logic [sgmd_pkg::HGT_W-1:0] h_eff;
    logic             lastcol, lastrow, has_out, job_last;
    logic [1:0]       next_kind;
    logic [1:0]       cl, cm, cr, rt, rm, rb;
    logic signed [G_W-1:0] gx, gy;
    logic [sgmd_pkg::POS_W-1:0] jx, jy;

    assign accept = i_push && !o_full;
    assign o_full = (r_state != S_IDLE);

    // clamp frame size
    always_comb begin
        if (i_cfg.frame_width < 12'd2) begin
            w_eff = EW'(2);
        end else if (EW'(i_cfg.frame_width) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height < 12'd2) begin
            h_eff = sgmd_pkg::HGT_W'(2);
        end else if (i_cfg.frame_height > sgmd_pkg::MAX_HEIGHT) begin
            h_eff = sgmd_pkg::HGT_W'(sgmd_pkg::MAX_HEIGHT);
        end else begin
            h_eff = sgmd_pkg::HGT_W'(i_cfg.frame_height);
        end
    end

    assign lastcol = EW'(r_col) >= (w_eff - 1'b1);
    assign lastrow = sgmd_pkg::HGT_W'(r_row) >= (h_eff - 1'b1);
    assign has_out = (r_row != '0) && (r_col != '0);

    always_comb begin
        pix_sum = PIX_W'(i_sample_a);
        if (i_cfg.channel_count >= 2'd2) begin
            pix_sum = pix_sum + PIX_W'(i_sample_b);
        end
        if (i_cfg.channel_count == 2'd3) begin
            pix_sum = pix_sum + PIX_W'(i_sample_c);
        end
    end

    assign top_v = (r_row <= sgmd_pkg::ROW_W'(1)) ? r_mid_rd : r_far_rd;

    // line stores
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid_rd <= mem_near[r_col];
            r_far_rd <= mem_far[r_col];
            r_pix    <= pix_sum;
        end
        if (r_state == S_READ) begin
            mem_far[r_col]  <= r_mid_rd;
            mem_near[r_col] <= r_pix;
        end
    end

    // job selection: bit 1 of the kind moves to the right column, bit 0 to the lower row
    always_comb begin
        if (r_kind[1]) begin
            cl = 2'd1; cm = 2'd2; cr = 2'd2;
            jx = sgmd_pkg::POS_W'(r_col);
        end else begin
            cl = (r_col == AW'(1)) ? 2'd1 : 2'd0; cm = 2'd1; cr = 2'd2;
            jx = sgmd_pkg::POS_W'(r_col - 1'b1);
        end
        if (r_kind[0]) begin
            rt = 2'd1; rm = 2'd2; rb = 2'd2;
            jy = sgmd_pkg::POS_W'(r_row);
        end else begin
            rt = 2'd0; rm = 2'd1; rb = 2'd2;
            jy = sgmd_pkg::POS_W'(r_row - 1'b1);
        end
        gx = (G_W'(r_win[rt][cr]) + (G_W'(r_win[rm][cr]) << 1) + G_W'(r_win[rb][cr]))
           - (G_W'(r_win[rt][cl]) + (G_W'(r_win[rm][cl]) << 1) + G_W'(r_win[rb][cl]));
        gy = (G_W'(r_win[rb][cl]) + (G_W'(r_win[rb][cm]) << 1) + G_W'(r_win[rb][cr]))
           - (G_W'(r_win[rt][cl]) + (G_W'(r_win[rt][cm]) << 1) + G_W'(r_win[rt][cr]));
    end

    always_comb begin
        next_kind = r_kind;
        job_last  = 1'b1;
        case (r_kind)
            2'd0: begin
                if (r_jobs[1]) begin
                    next_kind = 2'd1; job_last = 1'b0;
                end else if (r_jobs[2]) begin
                    next_kind = 2'd2; job_last = 1'b0;
                end
            end
            2'd1: begin
                if (r_jobs[2]) begin
                    next_kind = 2'd2; job_last = 1'b0;
                end
            end
            2'd2: begin
                if (r_jobs[3]) begin
                    next_kind = 2'd3; job_last = 1'b0;
                end
            end
            default: begin
                job_last = 1'b1;
            end
        endcase
    end

    assign o_job_push = (r_state == S_EMIT);
    assign o_job = {gx, gy, jx, jy, job_last, (r_kind == 2'd3)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_jobs    <= '0;
            r_kind    <= '0;
            r_lastcol <= 1'b0;
            r_lastrow <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= top_v;
                    r_win[1][2] <= r_mid_rd;
                    r_win[2][2] <= r_pix;
                    r_lastcol   <= lastcol;
                    r_lastrow   <= lastrow;
                    r_jobs      <= {lastrow && lastcol, lastcol, lastrow, 1'b1} & {4{has_out}};
                    r_kind      <= 2'd0;
                    if (has_out) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                        if (lastcol) begin
                            r_col <= '0;
                            r_row <= lastrow ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (!i_job_full) begin
                        if (job_last) begin
                            r_state <= S_IDLE;
                            if (r_lastcol) begin
                                r_col <= '0;
                                r_row <= r_lastrow ? '0 : r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end else begin
                            r_kind <= next_kind;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/sgmd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_back
// iterative square root and cordic angle unit, one job at a time
// ---------------------------------------------------------------------------
module sgmd_back #(
    parameter int SAMPLE_BITS = 8,
    parameter int JOB_W       = 2 * (SAMPLE_BITS + 5) + 2 * sgmd_pkg::POS_W + 2,
    parameter int RES_W       = 2 * sgmd_pkg::POS_W + sgmd_pkg::MAG_W + sgmd_pkg::DIR_W + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_res_push,
    input  logic             i_res_full,
    output logic [RES_W-1:0] o_res
);
    localparam int G_W   = SAMPLE_BITS + 5;
    localparam int A_W   = G_W - 1;
    localparam int SQ_W  = 2 * G_W;
    localparam int RT_W  = SQ_W / 2;
    localparam int XY_W  = G_W + 19;
    localparam int NITER = (RT_W > sgmd_pkg::CORDIC_N) ? RT_W : sgmd_pkg::CORDIC_N;
    localparam int CN_W  = $clog2(NITER);
    localparam int Z_W   = sgmd_pkg::Z_W;
    localparam int D_W   = sgmd_pkg::DIR_W;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [CN_W-1:0]       r_cnt;
    logic [A_W-1:0]        r_ax, r_ay;
    logic                  r_gxn, r_gyn, r_last, r_eof;
    logic [sgmd_pkg::POS_W-1:0] r_x, r_y;
    logic [SQ_W-1:0]       r_v, r_bit;
    // partial root carries the trial bit at its scaled position
    logic [SQ_W-1:0]       r_root;
    logic signed [XY_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0] r_z;

    logic signed [G_W-1:0] jgx, jgy;
    logic [sgmd_pkg::POS_W-1:0] jx, jy;
    logic                  jlast, jeof;
    logic [A_W-1:0]        ax, ay;
    logic [SQ_W-1:0]       trial;
    logic signed [XY_W-1:0] sx, sy;
    logic [3:0]            sh;
    logic signed [Z_W-1:0] zr;
    logic signed [D_W-1:0] ang, dir;

    assign {jgx, jgy, jx, jy, jlast, jeof} = i_job;
    assign ax = A_W'(jgx[G_W-1] ? -jgx : jgx);
    assign ay = A_W'(jgy[G_W-1] ? -jgy : jgy);

    assign o_job_pop  = (r_state == B_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == B_DONE);

    assign trial = r_root + r_bit;
    assign sh    = r_cnt[3:0];
    assign sx    = r_cx >>> sh;
    assign sy    = r_cy >>> sh;

    // final angle in the first quadrant, then mirror and sign
    always_comb begin
        zr = (r_z + Z_W'(128)) >>> 8;
        if (r_ay == '0) begin
            ang = '0;
        end else if (r_ax == '0) begin
            ang = D_W'(2048);
        end else if (r_ax == r_ay) begin
            ang = D_W'(1024);
        end else if (zr < 0) begin
            ang = '0;
        end else if (zr > Z_W'(2048)) begin
            ang = D_W'(2048);
        end else begin
            ang = D_W'(zr);
        end
        dir = r_gxn ? (D_W'(4096) - ang) : ang;
        if (r_gyn) begin
            dir = -dir;
        end
    end

    assign o_res = {r_x, r_y, sgmd_pkg::MAG_W'(r_root), dir, r_last, r_eof};

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_ax   <= ax;
            r_ay   <= ay;
            r_gxn  <= jgx[G_W-1];
            r_gyn  <= jgy[G_W-1];
            r_x    <= jx;
            r_y    <= jy;
            r_last <= jlast;
            r_eof  <= jeof;
            r_v    <= (SQ_W'(ax) * SQ_W'(ax)) + (SQ_W'(ay) * SQ_W'(ay));
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
            r_root <= '0;
            r_cx   <= XY_W'(ax) <<< 16;
            r_cy   <= XY_W'(ay) <<< 16;
            r_z    <= '0;
        end else if (r_state == B_RUN) begin
            if ({1'b0, r_cnt} < (CN_W + 1)'(RT_W)) begin
                if (r_v >= trial) begin
                    r_v    <= r_v - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if ({1'b0, r_cnt} < (CN_W + 1)'(sgmd_pkg::CORDIC_N)) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + sy;
                    r_cy <= r_cy - sx;
                    r_z  <= r_z + sgmd_pkg::atan_entry(sh);
                end else begin
                    r_cx <= r_cx - sy;
                    r_cy <= r_cy + sx;
                    r_z  <= r_z - sgmd_pkg::atan_entry(sh);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= B_RUN;
                        r_cnt   <= '0;
                    end
                end
                B_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CN_W'(NITER - 1)) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (!i_res_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/sobel_gradient_magnitude_direction_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_direction_top
// 3x3 sobel gradient magnitude and direction over a raster pixel stream
// ---------------------------------------------------------------------------
//  channel   handshake              word
//  pixel in  push / full            i_sample_a, i_sample_b, i_sample_c
//  result    empty / pop            o_pixel_x, o_pixel_y, o_magnitude,
//                                   o_direction, o_last_of_run, o_end_of_frame
//  config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  a pixel holds the intake through the registered line store read, then
//  the job emitter (0 to 4 gradient jobs), which waits on a full job queue
//  each job is loaded, iterated and handed off by the shared root and
//  cordic unit, one job at a time; that unit sets the result rate
//  a 4-deep job queue and a 4-deep result queue let the sides stall apart
//  synchronous active-low reset clears counters, window and queues; line
//  stores are not cleared and need no clearing pass
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude_direction_top #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // pixel words
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] i_sample_a,
    input  logic [SAMPLE_BITS-1:0] i_sample_b,
    input  logic [SAMPLE_BITS-1:0] i_sample_c,
    // result words
    output logic                   empty,
    input  logic                   pop,
    output logic [10:0]            o_pixel_x,
    output logic [10:0]            o_pixel_y,
    output logic [12:0]            o_magnitude,
    output logic signed [13:0]     o_direction,
    output logic                   o_last_of_run,
    output logic                   o_end_of_frame,
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [11:0]            i_cfg_data
);
    // job word: gx, gy, x, y, last, eof
    localparam int JOB_W = 2 * (SAMPLE_BITS + 5) + 2 * sgmd_pkg::POS_W + 2;
    localparam int RES_W = 2 * sgmd_pkg::POS_W + sgmd_pkg::MAG_W + sgmd_pkg::DIR_W + 2;

    sgmd_pkg::t_cfg r_cfg;

    logic             job_push, job_full, job_empty, job_pop;
    logic [JOB_W-1:0] job_in, job_out;
    logic             res_push, res_full;
    logic [RES_W-1:0] res_in, res_out;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= sgmd_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height  <= sgmd_pkg::RST_FRAME_HEIGHT;
            r_cfg.channel_count <= sgmd_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sgmd_pkg::REG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data;
                sgmd_pkg::REG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data;
                sgmd_pkg::REG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[1:0];
                default: begin
                    // unused index
                end
            endcase
        end
    end

    // front: intake, line stores, window, job list
    sgmd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_sample_a (i_sample_a),
        .i_sample_b (i_sample_b),
        .i_sample_c (i_sample_c),
        .o_job_push (job_push),
        .i_job_full (job_full),
        .o_job      (job_in)
    );

    // decoupling queue between the two halves
    sgmd_queue #(.W(JOB_W), .DEPTH(4)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // back: root and angle
    sgmd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .JOB_W       (JOB_W),
        .RES_W       (RES_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    // result queue drives the output side
    sgmd_queue #(.W(RES_W), .DEPTH(4)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign {o_pixel_x, o_pixel_y, o_magnitude, o_direction, o_last_of_run,
            o_end_of_frame} = res_out;
endmodule

// ===== rtl/sgmd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgmd_checker
// port-level checks on the sobel unit, bound to the top level
// ---------------------------------------------------------------------------
module sgmd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [12:0]        o_magnitude,
    input logic signed [13:0] o_direction
);
    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // the intake closes after each accepted pixel
    a_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("pixel intake open right after a word");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_magnitude) && $stable(o_direction)))
        else $error("waiting result changed");

    // angle stays within plus or minus pi
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_direction >= -14'sd4096 && o_direction <= 14'sd4096))
        else $error("direction out of range");
endmodule

bind sobel_gradient_magnitude_direction_top sgmd_checker u_sgmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_magnitude (o_magnitude),
    .o_direction (o_direction)
);
